/* design/lpcsf_pkg.sv */
// Shared widths, types and register indexes of the LPC synthesis filter.
`default_nettype none
package lpcsf_pkg;

    localparam int MAX_ORDER  = 16;
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int GAIN_W     = 16;
    localparam int ORDER_W    = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int MUL_W      = 17;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int ACC_W      = 38;
    localparam int HIST_IDX_W = $clog2(MAX_ORDER);

    typedef logic signed [SAMPLE_W-1:0]   sample_t;
    typedef logic signed [COEF_W-1:0]     coef_t;
    typedef logic        [GAIN_W-1:0]     gain_t;
    typedef logic        [ORDER_W-1:0]    order_t;
    typedef logic        [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic        [CFG_DATA_W-1:0] cfg_data_t;

    localparam cfg_idx_t REG_FILTER_ORDER   = 3'd0;
    localparam cfg_idx_t REG_GAIN           = 3'd1;
    localparam cfg_idx_t REG_COEFS_0_TO_3   = 3'd2;
    localparam cfg_idx_t REG_COEFS_4_TO_7   = 3'd3;
    localparam cfg_idx_t REG_COEFS_8_TO_11  = 3'd4;
    localparam cfg_idx_t REG_COEFS_12_TO_15 = 3'd5;

    localparam gain_t GAIN_RESET = 16'd4096;

endpackage
`default_nettype wire

/* design/lpcsf_if.sv */
// Handshake channels of the LPC synthesis filter: excitation, synthesis and config.
`default_nettype none
interface lpcsf_excite_if;
    logic                    valid;
    logic                    ready;
    lpcsf_pkg::sample_t      residual_sample;
    logic                    start_of_block;
    modport source (output valid, output residual_sample, output start_of_block, input ready);
    modport sink   (input valid, input residual_sample, input start_of_block, output ready);
endinterface

interface lpcsf_synth_if;
    logic                    valid;
    logic                    ready;
    lpcsf_pkg::sample_t      output_sample;
    logic                    saturated;
    modport source (output valid, output output_sample, output saturated, input ready);
    modport sink   (input valid, input output_sample, input saturated, output ready);
endinterface

interface lpcsf_cfg_if;
    logic                    valid;
    logic                    ready;
    lpcsf_pkg::cfg_idx_t     index;
    lpcsf_pkg::cfg_data_t    data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* design/lpc_synthesis_filter.sv */
// All-pole LPC synthesis filter with one shared multiply-accumulate unit.
//
//  channel   role   payload                              beat
//  excite    sink   residual_sample, start_of_block      one sample in
//  synth     source output_sample, saturated             one sample out
//  cfg       sink   index, data                          one register write
//
// A sample is taken in the idle state, where e*gain is formed on the shared 17x17
// multiplier; each MAC step then subtracts one coefficient product, and the round step
// rounds, saturates and updates the history. At order zero the MAC steps are skipped.
// Reset clears history, coefficients, order and sets gain to 1.0; cfg is always ready.
// A result waiting on synth stalls only the round step; excite is ready while idle.
`default_nettype none
module lpc_synthesis_filter (
    input  wire logic         clk,
    input  wire logic         rst_n,
    lpcsf_excite_if.sink      excite,
    lpcsf_synth_if.source     synth,
    lpcsf_cfg_if.sink         cfg
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MAC   = 2'd1;
    localparam logic [1:0] ST_ROUND = 2'd2;

    logic [1:0]                        state_reg, state_next;
    lpcsf_pkg::order_t                 order_reg, order_next;
    lpcsf_pkg::gain_t                  gain_reg, gain_next;
    lpcsf_pkg::coef_t                  coef_reg [lpcsf_pkg::MAX_ORDER];
    lpcsf_pkg::coef_t                  coef_next [lpcsf_pkg::MAX_ORDER];
    lpcsf_pkg::sample_t                hist_reg [lpcsf_pkg::MAX_ORDER];
    lpcsf_pkg::sample_t                hist_next [lpcsf_pkg::MAX_ORDER];
    logic signed [lpcsf_pkg::ACC_W-1:0] acc_reg, acc_next;
    lpcsf_pkg::order_t                 cnt_reg, cnt_next;
    logic                              out_valid_reg, out_valid_next;
    lpcsf_pkg::sample_t                out_sample_reg, out_sample_next;
    logic                              out_sat_reg, out_sat_next;

    lpcsf_pkg::order_t                   order_eff;
    logic signed [lpcsf_pkg::MUL_W-1:0]  op_a, op_b;
    logic signed [lpcsf_pkg::PROD_W-1:0] prod;
    logic signed [lpcsf_pkg::ACC_W-1:0]  prod_ext;
    logic signed [lpcsf_pkg::ACC_W-1:0]  rnd_sum;
    logic signed [lpcsf_pkg::ACC_W-13:0] rnd_q;
    logic                                sat_hi, sat_lo;
    logic [lpcsf_pkg::HIST_IDX_W-1:0]    tap;
    logic [1:0]                          slot;
    logic                                excite_beat, out_load;

    assign order_eff = (order_reg > lpcsf_pkg::ORDER_W'(lpcsf_pkg::MAX_ORDER))
                       ? lpcsf_pkg::ORDER_W'(lpcsf_pkg::MAX_ORDER) : order_reg;
    assign tap       = cnt_reg[lpcsf_pkg::HIST_IDX_W-1:0];

    assign excite.ready = (state_reg == ST_IDLE);
    assign excite_beat  = excite.valid && excite.ready;
    assign cfg.ready    = 1'b1;

    assign synth.valid         = out_valid_reg;
    assign synth.output_sample = out_sample_reg;
    assign synth.saturated     = out_sat_reg;

    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            op_a = {excite.residual_sample[lpcsf_pkg::SAMPLE_W-1], excite.residual_sample};
            op_b = {1'b0, gain_reg};
        end
        else
        begin
            op_a = {coef_reg[tap][lpcsf_pkg::COEF_W-1], coef_reg[tap]};
            op_b = {hist_reg[tap][lpcsf_pkg::SAMPLE_W-1], hist_reg[tap]};
        end
    end

    assign prod     = op_a * op_b;
    assign prod_ext = {{(lpcsf_pkg::ACC_W - lpcsf_pkg::PROD_W){prod[lpcsf_pkg::PROD_W-1]}},
                       prod};

    assign rnd_sum = acc_reg + lpcsf_pkg::ACC_W'(2048);
    assign rnd_q   = rnd_sum[lpcsf_pkg::ACC_W-1:12];
    assign sat_hi  = rnd_q > 26'sd32767;
    assign sat_lo  = rnd_q < -26'sd32768;
    assign out_load = (state_reg == ST_ROUND) && (!out_valid_reg || synth.ready);

    assign slot = 2'(cfg.index - lpcsf_pkg::REG_COEFS_0_TO_3);

    always_comb
    begin
        state_next      = state_reg;
        order_next      = order_reg;
        gain_next       = gain_reg;
        coef_next       = coef_reg;
        hist_next       = hist_reg;
        acc_next        = acc_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg && !synth.ready;
        out_sample_next = out_sample_reg;
        out_sat_next    = out_sat_reg;

        if (cfg.valid)
        begin
            case (cfg.index)
                lpcsf_pkg::REG_FILTER_ORDER:
                    order_next = cfg.data[lpcsf_pkg::ORDER_W-1:0];
                lpcsf_pkg::REG_GAIN:
                    gain_next = cfg.data[lpcsf_pkg::GAIN_W-1:0];
                lpcsf_pkg::REG_COEFS_0_TO_3, lpcsf_pkg::REG_COEFS_4_TO_7,
                lpcsf_pkg::REG_COEFS_8_TO_11, lpcsf_pkg::REG_COEFS_12_TO_15:
                begin
                    for (int k = 0; k < 4; k++)
                    begin
                        coef_next[{slot, 2'(k)}] = cfg.data[k*lpcsf_pkg::COEF_W +:
                                                            lpcsf_pkg::COEF_W];
                    end
                end
                default:
                begin
                end
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (excite_beat)
                begin
                    if (excite.start_of_block)
                    begin
                        for (int i = 0; i < lpcsf_pkg::MAX_ORDER; i++)
                        begin
                            hist_next[i] = '0;
                        end
                    end
                    acc_next   = prod_ext;
                    cnt_next   = '0;
                    state_next = (order_eff == '0) ? ST_ROUND : ST_MAC;
                end
            end
            ST_MAC:
            begin
                acc_next = acc_reg - prod_ext;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_next == order_eff)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (out_load)
                begin
                    if (sat_hi)
                    begin
                        out_sample_next = 16'sh7FFF;
                    end
                    else if (sat_lo)
                    begin
                        out_sample_next = -16'sh8000;
                    end
                    else
                    begin
                        out_sample_next = rnd_q[lpcsf_pkg::SAMPLE_W-1:0];
                    end
                    out_sat_next   = sat_hi || sat_lo;
                    out_valid_next = 1'b1;
                    for (int i = lpcsf_pkg::MAX_ORDER - 1; i > 0; i--)
                    begin
                        hist_next[i] = hist_reg[i-1];
                    end
                    hist_next[0] = out_sample_next;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            order_reg     <= '0;
            gain_reg      <= lpcsf_pkg::GAIN_RESET;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            for (int i = 0; i < lpcsf_pkg::MAX_ORDER; i++)
            begin
                coef_reg[i] <= '0;
                hist_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            order_reg     <= order_next;
            gain_reg      <= gain_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            coef_reg      <= coef_next;
            hist_reg      <= hist_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg        <= acc_next;
        out_sample_reg <= out_sample_next;
        out_sat_reg    <= out_sat_next;
    end

endmodule
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
// Testbench for the LPC synthesis filter: fixed-point shadow predictor, random beat idling.
module tb;

    localparam lpcsf_pkg::cfg_idx_t REG_SPARE_6 = 3'd6;
    localparam lpcsf_pkg::cfg_idx_t REG_SPARE_7 = 3'd7;
    localparam int RANDOM_ITEMS  = 850;
    localparam int SETTLE_CYCLES = lpcsf_pkg::MAX_ORDER + 8;

    typedef lpcsf_pkg::coef_t coef_bank_t [lpcsf_pkg::MAX_ORDER];
    typedef struct packed {
        lpcsf_pkg::sample_t sample;
        logic               saturated;
    } synth_beat_t;

    logic clk = 1'b0;
    logic rst_n;
    logic steady;
    int   mismatches = 0;

    lpcsf_pkg::order_t  order_q;
    lpcsf_pkg::gain_t   gain_q;
    coef_bank_t         coef_q;
    lpcsf_pkg::sample_t history [lpcsf_pkg::MAX_ORDER];
    synth_beat_t        expected_samples [$];

    lpcsf_excite_if excite ();
    lpcsf_synth_if  synth ();
    lpcsf_cfg_if    cfg ();

    lpc_synthesis_filter dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .excite (excite),
        .synth  (synth),
        .cfg    (cfg)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end

    function automatic synth_beat_t synthesize_sample(lpcsf_pkg::sample_t e, logic sob);
        longint      acc;
        longint      rounded;
        int          taps;
        synth_beat_t beat;
        if (sob)
            foreach (history[i])
                history[i] = '0;
        taps = (order_q > lpcsf_pkg::MAX_ORDER) ? lpcsf_pkg::MAX_ORDER : int'(order_q);
        acc = longint'(e) * longint'(gain_q);
        for (int i = 0; i < taps; i++)
            acc -= longint'(coef_q[i]) * longint'(history[i]);
        rounded = (acc + 2048) >>> 12;
        beat.saturated = 1'b1;
        if (rounded > 32767)
            rounded = 32767;
        else if (rounded < -32768)
            rounded = -32768;
        else
            beat.saturated = 1'b0;
        beat.sample = lpcsf_pkg::sample_t'(rounded);
        for (int i = lpcsf_pkg::MAX_ORDER - 1; i > 0; i--)
            history[i] = history[i - 1];
        history[0] = beat.sample;
        return beat;
    endfunction

    function automatic void apply_register(lpcsf_pkg::cfg_idx_t idx,
                                           lpcsf_pkg::cfg_data_t data);
        case (idx)
            lpcsf_pkg::REG_FILTER_ORDER:
                order_q = data[lpcsf_pkg::ORDER_W-1:0];
            lpcsf_pkg::REG_GAIN:
                gain_q = data[lpcsf_pkg::GAIN_W-1:0];
            lpcsf_pkg::REG_COEFS_0_TO_3, lpcsf_pkg::REG_COEFS_4_TO_7,
            lpcsf_pkg::REG_COEFS_8_TO_11, lpcsf_pkg::REG_COEFS_12_TO_15:
                for (int k = 0; k < 4; k++)
                    coef_q[int'(idx - lpcsf_pkg::REG_COEFS_0_TO_3) * 4 + k] =
                        data[lpcsf_pkg::COEF_W*k +: lpcsf_pkg::COEF_W];
            default:
                ;
        endcase
    endfunction

    function automatic coef_bank_t random_bank(int mag);
        coef_bank_t bank;
        foreach (bank[i])
            bank[i] = (mag == 0) ? lpcsf_pkg::coef_t'($urandom)
                                 : lpcsf_pkg::coef_t'(int'($urandom_range(2 * mag)) - mag);
        return bank;
    endfunction

    function automatic lpcsf_pkg::sample_t random_residual();
        case ($urandom_range(3))
            0:       return lpcsf_pkg::sample_t'($urandom);
            1:       return lpcsf_pkg::sample_t'(int'($urandom_range(2000)) - 1000);
            default: return lpcsf_pkg::sample_t'(int'($urandom_range(16000)) - 8000);
        endcase
    endfunction

    task automatic write_reg(lpcsf_pkg::cfg_idx_t idx, lpcsf_pkg::cfg_data_t data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        do @(posedge clk); while (!cfg.ready);
        apply_register(idx, data);
    endtask

    // drop the excitation beat, drain every expected sample, let the datapath go idle
    task automatic settle();
        excite.valid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_filter(lpcsf_pkg::order_t order, lpcsf_pkg::gain_t g,
                                  coef_bank_t bank);
        lpcsf_pkg::cfg_data_t word;
        settle();
        word = {$urandom, $urandom};
        word[lpcsf_pkg::ORDER_W-1:0] = order;
        write_reg(lpcsf_pkg::REG_FILTER_ORDER, word);
        word = {$urandom, $urandom};
        word[lpcsf_pkg::GAIN_W-1:0] = g;
        write_reg(lpcsf_pkg::REG_GAIN, word);
        write_reg(lpcsf_pkg::REG_COEFS_0_TO_3,   {bank[3],  bank[2],  bank[1],  bank[0]});
        write_reg(lpcsf_pkg::REG_COEFS_4_TO_7,   {bank[7],  bank[6],  bank[5],  bank[4]});
        write_reg(lpcsf_pkg::REG_COEFS_8_TO_11,  {bank[11], bank[10], bank[9],  bank[8]});
        write_reg(lpcsf_pkg::REG_COEFS_12_TO_15, {bank[15], bank[14], bank[13], bank[12]});
        cfg.valid <= 1'b0;
    endtask

    task automatic send_sample(lpcsf_pkg::sample_t e, logic sob);
        while (!steady && $urandom_range(99) < 10)
        begin
            excite.valid <= 1'b0;
            @(posedge clk);
        end
        excite.valid           <= 1'b1;
        excite.residual_sample <= e;
        excite.start_of_block  <= sob;
        do @(posedge clk); while (!excite.ready);
        expected_samples.push_back(synthesize_sample(e, sob));
    endtask

    task automatic test_reset_state();
        send_sample(16'sd32767, 1'b1);
        send_sample(-16'sd32768, 1'b0);
        send_sample(16'sd1, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd0, 1'b0);
    endtask

    task automatic test_gain_extremes();
        coef_bank_t bank;
        bank = random_bank(0);
        program_filter('0, '1, bank);
        send_sample(16'sd32767, 1'b1);
        send_sample(-16'sd32768, 1'b0);
        send_sample(16'sd1, 1'b0);
        send_sample(-16'sd1, 1'b0);
        program_filter('0, '0, bank);
        send_sample(-16'sd32768, 1'b0);
    endtask

    task automatic test_full_order();
        coef_bank_t bank;
        foreach (bank[i])
            bank[i] = lpcsf_pkg::coef_t'(16'h8000);
        program_filter(lpcsf_pkg::order_t'(lpcsf_pkg::MAX_ORDER), lpcsf_pkg::GAIN_RESET, bank);
        send_sample(16'sd32767, 1'b1);
        send_sample(-16'sd32768, 1'b0);
        send_sample(16'sd12345, 1'b0);
        foreach (bank[i])
            bank[i] = lpcsf_pkg::coef_t'(16'h7FFF);
        program_filter(lpcsf_pkg::order_t'(lpcsf_pkg::MAX_ORDER), lpcsf_pkg::GAIN_RESET, bank);
        send_sample(-16'sd32768, 1'b1);
        send_sample(16'sd32767, 1'b0);
        send_sample(-16'sd1, 1'b0);
    endtask

    task automatic test_order_above_max();
        program_filter('1, 16'd3000, random_bank(300));
        send_sample(random_residual(), 1'b1);
        send_sample(random_residual(), 1'b0);
        send_sample(random_residual(), 1'b0);
        program_filter(lpcsf_pkg::order_t'(lpcsf_pkg::MAX_ORDER + 1), lpcsf_pkg::GAIN_RESET,
                       random_bank(500));
        send_sample(random_residual(), 1'b1);
    endtask

    task automatic test_spare_index();
        settle();
        write_reg(REG_SPARE_6, '1);
        write_reg(REG_SPARE_7, {$urandom, $urandom});
        cfg.valid <= 1'b0;
        send_sample(16'sd20000, 1'b1);
        send_sample(-16'sd20000, 1'b0);
    endtask

    task automatic test_random_blocks();
        int                sent;
        int                phase;
        int                block_len;
        lpcsf_pkg::order_t order;
        lpcsf_pkg::gain_t  g;
        coef_bank_t        bank;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            steady <= (phase == 5);
            case ($urandom_range(9))
                0:       order = lpcsf_pkg::order_t'($urandom_range(31));
                1:       order = '0;
                default: order = lpcsf_pkg::order_t'($urandom_range(lpcsf_pkg::MAX_ORDER, 1));
            endcase
            case ($urandom_range(7))
                0:       g = '1;
                1:       g = '0;
                2:       g = lpcsf_pkg::gain_t'($urandom);
                default: g = lpcsf_pkg::gain_t'($urandom_range(6000, 1000));
            endcase
            case ($urandom_range(5))
                0:       bank = random_bank(0);
                1:       bank = random_bank(3000);
                default: bank = random_bank(400);
            endcase
            program_filter(order, g, bank);
            repeat ($urandom_range(4, 1))
            begin
                block_len = $urandom_range(40, 1);
                for (int n = 0; n < block_len; n++)
                begin
                    send_sample(random_residual(),
                                (n == 0) ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0));
                    sent++;
                end
            end
            phase++;
        end
        steady <= 1'b0;
    endtask

    always @(posedge clk)
        synth.ready <= steady || ($urandom_range(99) >= 10);

    always @(posedge clk)
    begin : check_synth
        synth_beat_t want;
        if (rst_n && synth.valid && synth.ready)
        begin
            if (expected_samples.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output beat: sample %0d saturated %0b",
                             synth.output_sample, synth.saturated);
            end
            else
            begin
                want = expected_samples.pop_front();
                if (synth.output_sample !== want.sample || synth.saturated !== want.saturated)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("output mismatch: expected %0d sat %0b, got %0d sat %0b",
                                 want.sample, want.saturated,
                                 synth.output_sample, synth.saturated);
                end
            end
        end
    end

    initial
    begin
        rst_n                  = 1'b0;
        steady                 = 1'b0;
        excite.valid           = 1'b0;
        excite.residual_sample = '0;
        excite.start_of_block  = 1'b0;
        cfg.valid              = 1'b0;
        cfg.index              = lpcsf_pkg::REG_FILTER_ORDER;
        cfg.data               = '0;
        order_q                = '0;
        gain_q                 = lpcsf_pkg::GAIN_RESET;
        foreach (coef_q[i])
            coef_q[i] = '0;
        foreach (history[i])
            history[i] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_gain_extremes();
        test_full_order();
        test_order_above_max();
        test_spare_index();
        test_random_blocks();

        settle();
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
